[rtl/vrt_pkg.sv]
// Package for the voxel ray walker: payload structs, codes and fixed widths.
// Used by vrt_div and voxel_ray_traversal.
package vrt_pkg;

  typedef struct packed {
    logic               mode;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               cell_solid;
  } vrt_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
    logic [2:0]         face;
    logic [15:0]        distance;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic signed [23:0] hit_z;
  } vrt_out_t;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;

  localparam logic [2:0] FACE_NONE = 3'd0;
  localparam logic [2:0] FACE_UP   = 3'd3;

  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  localparam logic [1:0] REG_REACH    = 2'd0;
  localparam logic [1:0] REG_EYE      = 2'd1;
  localparam logic [1:0] REG_WORLD_H  = 2'd2;

  localparam logic [31:0] INF32 = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_STEP,
    ST_MUL,
    ST_HIT,
    ST_OUT
  } vrt_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } vrt_div_req_t;

endpackage

[rtl/vrt_div.sv]
// Restoring divider, one quotient bit a cycle.
// Depends on vrt_pkg.
module vrt_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vrt_pkg::vrt_div_req_t req,
  output logic                  done,
  output logic [31:0]           quotient
);
  import vrt_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // divisor <= 32768 so the partial remainder fits 16 bits
      if (!trial[16]) begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[14:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/voxel_ray_traversal.sv]
// Voxel ray walker (3D DDA) top level: sequencer, step datapath, hit point.
// Depends on vrt_pkg and vrt_div.
//
//  channel | ports                      | flow
//  in      | in_valid, in_stall, in_data  | start or occupancy-answer beat
//  out     | out_valid, out_stall, out_data | query, hit or miss beat
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// A start beat runs six serial divisions (first crossing and span per axis) on
// one radix-2 divider, each through set-up, launch and wait states; a zero
// direction component skips its two in a single set-up state. Each walked cell
// then takes a step and a range check; an answer beat walks on the same way, or
// for a hit past the start cell uses one shared multiplier, a multiply and a sum
// per axis, then assembles. Reset is synchronous and clears control state.
// in_stall is high in reset and from acceptance until the result beat is taken.
module voxel_ray_traversal #(
  parameter int MAX_STEPS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrt_pkg::vrt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vrt_pkg::vrt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import vrt_pkg::*;

  localparam int SW = $clog2(MAX_STEPS + 1);

  vrt_state_t state_r, state_nxt;

  logic [15:0] reach_r;
  logic [9:0]  eye_r;
  logic [12:0] world_r;

  logic signed [15:0] cell_r   [3];
  logic [31:0]        next_r   [3];
  logic [31:0]        span_r   [3];
  logic [1:0]         sign_r   [3];
  logic signed [23:0] org_r    [3];
  logic signed [15:0] dir_r    [3];
  logic signed [23:0] pt_r     [3];
  logic [31:0]        travel_r;
  logic [2:0]         face_r;
  logic [SW-1:0]      steps_r;
  logic               active_r;
  logic [1:0]         ax_r;
  logic               phase_r;   // 0 first crossing, 1 span
  logic signed [47:0] prod_r;
  vrt_out_t           out_r;
  logic               outv_r;

  vrt_div_req_t div_req;
  logic         div_done;
  logic [31:0]  div_q;

  vrt_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quotient(div_q)
  );

  // setup: eye-adjusted origin
  logic signed [24:0] oy_sum;
  logic signed [23:0] org_in [3];
  assign oy_sum = 25'(in_data.origin_y) + 25'(signed'({1'b0, eye_r}));
  always_comb begin
    org_in[0] = in_data.origin_x;
    org_in[2] = in_data.origin_z;
    org_in[1] = (oy_sum > 25'sd8388607) ? 24'sd8388607 : oy_sum[23:0];
  end

  // divider operands for current axis
  logic signed [15:0] dcur;
  logic [15:0]        mag;
  logic [7:0]         frac;
  logic [8:0]         fdist;
  always_comb begin
    dcur  = dir_r[ax_r];
    mag   = dcur[15] ? 16'(-dcur) : dcur;
    frac  = org_r[ax_r][7:0];
    fdist = dcur[15] ? {1'b0, frac} : 9'd256 - {1'b0, frac};
    div_req.start    = (state_r == ST_DIV_GO);
    div_req.divisor  = mag;
    div_req.dividend = phase_r ? 32'h4000_0000 : {1'b0, fdist, 22'd0};
  end

  // step selection
  logic [1:0]  sel;
  logic [32:0] nsum;
  logic signed [15:0] cstep;
  logic        in_rng;
  logic        steps_done;
  logic        past_reach;
  always_comb begin
    if (next_r[0] < next_r[1]) sel = (next_r[0] < next_r[2]) ? 2'd0 : 2'd2;
    else                       sel = (next_r[1] < next_r[2]) ? 2'd1 : 2'd2;
    nsum  = {1'b0, next_r[sel]} + {1'b0, span_r[sel]};
    cstep = cell_r[sel];
    in_rng = !cell_r[1][15] && ({3'b000, cell_r[1][12:0]} == 16'(cell_r[1])) &&
             (cell_r[1][12:0] < world_r);
    steps_done = 32'(steps_r) >= 32'(MAX_STEPS);
    past_reach = next_r[sel] > {8'd0, reach_r, 8'd0};
  end

  // hit point: one axis multiplied at a time, its sum taken before the next multiply; floor by 2^22
  logic signed [48:0] pt_sum;
  always_comb begin
    pt_sum = 49'(org_r[ax_r]) + 49'(prod_r >>> 22);
  end

  vrt_out_t q_out, m_out;
  always_comb begin
    q_out = '0;
    q_out.kind = KIND_QUERY;
    q_out.cell_x = cell_r[0];
    q_out.cell_y = cell_r[1];
    q_out.cell_z = cell_r[2];
    m_out = '0;
    m_out.kind = KIND_MISS;
  end

  logic in_acc;
  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = rst_n;
  assign out_valid = outv_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_data.mode)         state_nxt = ST_SETUP;
          else if (!active_r)        state_nxt = ST_IDLE;
          else if (in_data.cell_solid) state_nxt = (face_r == FACE_NONE) ? ST_HIT : ST_MUL;
          else                       state_nxt = ST_STEP;
        end
      end
      ST_SETUP: begin
        if (dir_r[ax_r] != '0) state_nxt = ST_DIV_GO;
        else if (ax_r == 2'd2) state_nxt = ST_CHECK;
      end
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_nxt = (phase_r && ax_r == 2'd2) ? ST_CHECK : ST_SETUP;
      end
      ST_CHECK:    state_nxt = in_rng ? ST_OUT : ST_STEP;
      ST_STEP:     state_nxt = (steps_done || past_reach) ? ST_OUT : ST_CHECK;
      ST_MUL: begin
        if (phase_r && ax_r == 2'd2) state_nxt = ST_HIT;
      end
      ST_HIT:      state_nxt = ST_OUT;
      ST_OUT:      state_nxt = (!out_stall) ? ST_IDLE : ST_OUT;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      reach_r    <= 16'd1280;
      eye_r      <= 10'd410;
      world_r    <= 13'd256;
      active_r   <= 1'b0;
      outv_r     <= 1'b0;
      face_r     <= FACE_NONE;
      steps_r    <= '0;
      travel_r   <= '0;
      ax_r       <= '0;
      phase_r    <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        cell_r[a] <= '0; next_r[a] <= '0; span_r[a] <= '0;
        sign_r[a] <= SIGN_NONE; org_r[a] <= '0; dir_r[a] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_REACH:    reach_r    <= cfg_data;
          REG_EYE:      eye_r      <= cfg_data[9:0];
          REG_WORLD_H:  world_r    <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (outv_r && !out_stall) outv_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc && !in_data.mode) begin
            dir_r[0] <= in_data.dir_x;
            dir_r[1] <= in_data.dir_y;
            dir_r[2] <= in_data.dir_z;
            for (int a = 0; a < 3; a++) begin
              org_r[a]  <= org_in[a];
              cell_r[a] <= 16'(org_in[a] >>> 8);
            end
            travel_r <= '0;
            face_r   <= FACE_NONE;
            steps_r  <= '0;
            active_r <= 1'b1;
            ax_r     <= 2'd0;
            phase_r  <= 1'b0;
          end
          if (in_acc && in_data.mode && active_r && in_data.cell_solid) begin
            active_r <= 1'b0;
            ax_r     <= 2'd0;
          end
        end
        ST_SETUP: begin
          if (dir_r[ax_r] == '0) begin
            sign_r[ax_r] <= SIGN_NONE;
            span_r[ax_r] <= INF32;
            next_r[ax_r] <= INF32;
            phase_r <= 1'b0;
            if (ax_r != 2'd2) ax_r <= ax_r + 2'd1;
          end else begin
            sign_r[ax_r] <= dir_r[ax_r][15] ? SIGN_NEG : SIGN_POS;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (!phase_r) begin
              next_r[ax_r] <= div_q;
              phase_r <= 1'b1;
            end else begin
              span_r[ax_r] <= div_q;
              phase_r <= 1'b0;
              if (ax_r != 2'd2) ax_r <= ax_r + 2'd1;
            end
          end
        end
        ST_CHECK: begin
          // start cell is queried first if in the vertical range
          if (in_rng) begin
            out_r  <= q_out;
            outv_r <= 1'b1;
          end
        end
        ST_STEP: begin
          if (steps_done) begin
            active_r <= 1'b0;
            out_r    <= m_out;
            outv_r   <= 1'b1;
          end else begin
            next_r[sel] <= nsum[32] ? INF32 : nsum[31:0];
            if (sign_r[sel] == SIGN_POS) begin
              cell_r[sel] <= cstep + 16'sd1;
              face_r <= {sel, 1'b0} + 3'd1;
            end else if (sign_r[sel] == SIGN_NEG) begin
              cell_r[sel] <= cstep - 16'sd1;
              face_r <= {sel, 1'b0} + 3'd2;
            end
            travel_r <= next_r[sel];
            steps_r  <= steps_r + SW'(1);
            if (past_reach) begin
              active_r <= 1'b0;
              out_r    <= m_out;
              outv_r   <= 1'b1;
            end
          end
        end
        ST_MUL: begin
          if (!phase_r) begin
            // multiply for axis ax_r; the sum is taken on the next cycle
            prod_r  <= 48'(dir_r[ax_r]) * 48'(signed'({1'b0, travel_r}));
            phase_r <= 1'b1;
          end else begin
            pt_r[ax_r] <= (pt_sum > 49'sd8388607) ? 24'sd8388607 :
                          (pt_sum < -49'sd8388608) ? 24'sh80_0000 : pt_sum[23:0];
            phase_r <= 1'b0;
            if (ax_r != 2'd2) ax_r <= ax_r + 2'd1;
          end
        end
        ST_HIT: begin
          out_r.kind   <= KIND_HIT;
          out_r.cell_x <= cell_r[0];
          out_r.cell_y <= cell_r[1];
          out_r.cell_z <= cell_r[2];
          if (face_r == FACE_NONE) begin
            out_r.face     <= FACE_UP;
            out_r.distance <= '0;
            out_r.hit_x    <= org_r[0];
            out_r.hit_y    <= org_r[1];
            out_r.hit_z    <= org_r[2];
          end else begin
            out_r.face     <= face_r;
            out_r.distance <= (travel_r[31:24] != '0) ? 16'hFFFF : travel_r[23:8];
            out_r.hit_x    <= pt_r[0];
            out_r.hit_y    <= pt_r[1];
            out_r.hit_z    <= pt_r[2];
          end
          outv_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
